// ----- hw/rtl/utf8tok_pkg.sv -----
package utf8tok_pkg;

    localparam int CP_W       = 21;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_VAL   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_VAL   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_VAL   = 8'hF0;
    localparam logic [7:0] LEAD2_DATA  = 8'h1F;
    localparam logic [7:0] LEAD3_DATA  = 8'h0F;
    localparam logic [7:0] LEAD4_DATA  = 8'h07;

    localparam logic [CP_W-1:0] CP_ASCII_MAX = 21'h00007F;
    localparam logic [CP_W-1:0] CP_LAT1_LO   = 21'h0000C0;
    localparam logic [CP_W-1:0] CP_LAT1_HI   = 21'h0000FF;
    localparam logic [CP_W-1:0] CP_CYR_LO    = 21'h000400;
    localparam logic [CP_W-1:0] CP_CYR_HI    = 21'h0004FF;
    localparam logic [CP_W-1:0] CP_CASE_OFS  = 21'h000020;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       result_kind;
        logic       last_of_run;
    } result_t;

    // one entry per input byte that produces results: 0..2 token bytes, then optional marker
    typedef struct packed {
        logic [1:0] nbytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       marker;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_wr_t;

    function automatic logic is_word_point(input logic [CP_W-1:0] cp);
        logic w;
        w = ((cp >= CP_W'("a")) && (cp <= CP_W'("z")))
         || ((cp >= CP_W'("A")) && (cp <= CP_W'("Z")))
         || ((cp >= CP_W'("0")) && (cp <= CP_W'("9")))
         || (cp == CP_W'("'")) || (cp == CP_W'("-")) || (cp == CP_W'("$"))
         || ((cp >= CP_CYR_LO) && (cp <= CP_CYR_HI))
         || ((cp >= CP_LAT1_LO) && (cp <= CP_LAT1_HI));
        return w;
    endfunction

endpackage

// ----- hw/rtl/utf8_word_tokenizer_top.sv -----
// Result path: each command is registered in a queue slot, then in the output register.
// Throughput: one byte per cycle while full is low; one result beat per cycle on pop.
// Each byte makes 0..3 result beats; a 4-entry command queue between decode and
// output sequencing absorbs bursts, and full rises only when that queue is full.
// Reset (rst_n low, async) clears decode state, open-token flag and the queue.
module utf8_word_tokenizer_top
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    cmd_wr_t wr;
    cmd_t    q_cmd;
    logic    q_empty;
    logic    q_full;
    logic    q_rd;
    logic    accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    utf8tok_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (wr)
    );

    utf8tok_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (q_rd),
        .rd_cmd  (q_cmd),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    utf8tok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_cmd   (q_cmd),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ----- hw/rtl/utf8tok_front.sv -----
module utf8tok_front
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    output cmd_wr_t wr
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic            open_reg, open_next;

    logic [CP_W-1:0] acc_shift;
    logic [1:0]      rem_dec;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] cp_low;
    logic            done;
    logic            word;
    logic            open_mid;
    logic            close_now;
    cmd_t            cmd;

    assign acc_shift = {acc_reg[CP_W-7:0], item.in_byte[5:0]};
    assign rem_dec   = rem_reg - 2'd1;

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        cp       = '0;
        done     = 1'b0;
        priority if (rem_reg != 2'd0)
        begin
            rem_next = rem_dec;
            if (rem_dec == 2'd0)
            begin
                cp       = acc_shift;
                acc_next = '0;
                done     = 1'b1;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
        else if (item.in_byte < ASCII_LIMIT)
        begin
            cp   = CP_W'(item.in_byte);
            done = 1'b1;
        end
        else if ((item.in_byte & LEAD2_MASK) == LEAD2_VAL)
        begin
            acc_next = CP_W'(item.in_byte & LEAD2_DATA);
            rem_next = 2'd1;
        end
        else if ((item.in_byte & LEAD3_MASK) == LEAD3_VAL)
        begin
            acc_next = CP_W'(item.in_byte & LEAD3_DATA);
            rem_next = 2'd2;
        end
        else if ((item.in_byte & LEAD4_MASK) == LEAD4_VAL)
        begin
            acc_next = CP_W'(item.in_byte & LEAD4_DATA);
            rem_next = 2'd3;
        end
        else
        begin
            // bad lead byte decodes as code point zero
            cp   = '0;
            done = 1'b1;
        end

        if (item.end_of_text)
        begin
            acc_next = '0;
            rem_next = 2'd0;
        end
    end

    always_comb
    begin
        if ((cp >= CP_W'("A")) && (cp <= CP_W'("Z")))
            cp_low = cp + CP_CASE_OFS;
        else
            cp_low = cp;
        word = is_word_point(cp_low);

        cmd       = '0;
        open_mid  = open_reg;
        close_now = 1'b0;
        if (done && word)
        begin
            open_mid = 1'b1;
            if (cp_low <= CP_ASCII_MAX)
            begin
                cmd.nbytes = 2'd1;
                cmd.byte0  = cp_low[7:0];
            end
            else
            begin
                // word points above ASCII all fit in two bytes
                cmd.nbytes = 2'd2;
                cmd.byte0  = {3'b110, cp_low[10:6]};
                cmd.byte1  = {2'b10, cp_low[5:0]};
            end
        end
        else if (done && open_reg)
        begin
            open_mid  = 1'b0;
            close_now = 1'b1;
        end

        cmd.marker = close_now || (item.end_of_text && open_mid);
        open_next  = item.end_of_text ? 1'b0 : open_mid;

        wr.cmd   = cmd;
        wr.valid = accept && ((cmd.nbytes != 2'd0) || cmd.marker);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            open_reg <= open_next;
        end
    end

endmodule

// ----- hw/rtl/utf8tok_fifo.sv -----
module utf8tok_fifo
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_wr_t wr,
    input  logic    rd,
    output cmd_t    rd_cmd,
    output logic    q_empty,
    output logic    q_full
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr;
    logic              do_rd;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign rd_cmd  = slot_reg[rd_ptr_reg];
    assign do_wr   = wr.valid && !q_full;
    assign do_rd   = rd && !q_empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/utf8tok_back.sv -----
module utf8tok_back
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    q_cmd,
    input  logic    q_empty,
    output logic    q_rd,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    cmd_t       cmd_reg, cmd_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;

    logic [1:0] total;
    logic       last;
    logic       pop_ok;
    logic       load;

    assign total  = cmd_reg.nbytes + 2'(cmd_reg.marker);
    assign last   = (idx_reg == total - 2'd1);
    assign pop_ok = pop && valid_reg;
    assign load   = !valid_reg || (pop_ok && last);
    assign q_rd   = load && !q_empty;
    assign empty  = !valid_reg;

    always_comb
    begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            cmd_next   = q_cmd;
            valid_next = !q_empty;
            idx_next   = 2'd0;
        end
        else if (pop_ok)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_comb
    begin
        result.last_of_run = last;
        if (idx_reg < cmd_reg.nbytes)
        begin
            result.out_byte    = (idx_reg == 2'd0) ? cmd_reg.byte0 : cmd_reg.byte1;
            result.result_kind = KIND_BYTE;
        end
        else
        begin
            result.out_byte    = 8'h00;
            result.result_kind = KIND_MARKER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- hw/rtl/utf8tok_checker.sv -----
module utf8tok_checker
    import utf8tok_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input logic    full,
    input item_t   item,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // a waiting result beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.result_kind == KIND_MARKER)) |-> (result.out_byte == 8'h00))
        else $error("token-end marker with nonzero byte");

    // a lead byte is always followed by its continuation in the same run
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.result_kind == KIND_BYTE) && (result.out_byte[7:6] == 2'b11))
        |-> !result.last_of_run)
        else $error("lead byte ends a run");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queue not empty after reset");

endmodule

bind utf8_word_tokenizer_top utf8tok_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ----- test/utf8_word_tokenizer_checker.sv -----
`timescale 1ns / 100ps

module utf8_word_tokenizer_checker
    import utf8tok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  item_t   item,
    input  logic    empty,
    input  logic    pop,
    input  result_t result,
    output int      mismatches,
    output int      outstanding,
    output int      beats_checked
);

    // decoder copy
    logic [CP_W-1:0] code_acc;
    logic [1:0]      cont_left;
    logic            tok_open;

    result_t token_beats_q [$];

    function automatic logic is_token_char(input logic [CP_W-1:0] cp);
        return (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h30 && cp <= 21'h39)
            || cp == 21'h27 || cp == 21'h2D || cp == 21'h24
            || (cp >= 21'hC0 && cp <= 21'hFF) || (cp >= 21'h400 && cp <= 21'h4FF);
    endfunction

    function automatic result_t beat_of(input logic [7:0] b, input logic k);
        beat_of = '{out_byte: b, result_kind: k, last_of_run: 1'b0};
    endfunction

    task automatic tokenize_byte(input item_t it);
        logic [CP_W-1:0] cp;
        logic            done;
        result_t         run [3];
        int              n;
        int              i;
        cp   = '0;
        done = 1'b0;
        n    = 0;
        if (cont_left != 2'd0) begin
            // continuation bytes are taken blindly, low six bits only
            code_acc  = {code_acc[CP_W-7:0], it.in_byte[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp       = code_acc;
                code_acc = '0;
                done     = 1'b1;
            end
        end else if (!it.in_byte[7]) begin
            cp   = CP_W'(it.in_byte);
            done = 1'b1;
        end else if (it.in_byte[7:5] == 3'b110) begin
            code_acc  = CP_W'(it.in_byte[4:0]);
            cont_left = 2'd1;
        end else if (it.in_byte[7:4] == 4'b1110) begin
            code_acc  = CP_W'(it.in_byte[3:0]);
            cont_left = 2'd2;
        end else if (it.in_byte[7:3] == 5'b11110) begin
            code_acc  = CP_W'(it.in_byte[2:0]);
            cont_left = 2'd3;
        end else begin
            done = 1'b1;  // stray continuation or F8-FF lead: code point 0
        end

        if (done) begin
            if (cp >= 21'h41 && cp <= 21'h5A)  // A-Z
                cp = cp + 21'h20;
            if (is_token_char(cp)) begin
                if (cp <= 21'h7F) begin
                    run[n] = beat_of(cp[7:0], KIND_BYTE);
                    n = n + 1;
                end else begin
                    run[n] = beat_of({3'b110, cp[10:6]}, KIND_BYTE);
                    n = n + 1;
                    run[n] = beat_of({2'b10, cp[5:0]}, KIND_BYTE);
                    n = n + 1;
                end
                tok_open = 1'b1;
            end else if (tok_open) begin
                run[n] = beat_of(8'h00, KIND_MARKER);
                n = n + 1;
                tok_open = 1'b0;
            end
        end

        if (it.end_of_text) begin
            code_acc  = '0;
            cont_left = '0;
            if (tok_open) begin
                run[n] = beat_of(8'h00, KIND_MARKER);
                n = n + 1;
                tok_open = 1'b0;
            end
        end

        if (n > 0)
            run[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++)
            token_beats_q.insert(token_beats_q.size(), run[i]);
    endtask

    task automatic check_beat(input result_t got);
        result_t want;
        beats_checked++;
        if (token_beats_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected beat byte=%02h kind=%0d last=%0d",
                         $time, got.out_byte, got.result_kind, got.last_of_run);
        end else begin
            want = token_beats_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: beat %0d want %02h/%0d/%0d got %02h/%0d/%0d",
                             $time, beats_checked, want.out_byte, want.result_kind,
                             want.last_of_run, got.out_byte, got.result_kind,
                             got.last_of_run);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            code_acc      = '0;
            cont_left     = '0;
            tok_open      = 1'b0;
            token_beats_q.delete();
            mismatches    = 0;
            beats_checked = 0;
            outstanding  <= 0;
        end else begin
            // a beat popped at this edge can't come from the byte taken at this edge
            if (pop && !empty)
                check_beat(result);
            if (push && !full)
                tokenize_byte(item);
            outstanding <= token_beats_q.size();
        end
    end

endmodule

// ----- test/tb_utf8_word_tokenizer_top.sv -----
`timescale 1ns / 100ps

module tb_utf8_word_tokenizer_top;
    import utf8tok_pkg::*;

    localparam int ITEM_TARGET    = 460;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_mode_e;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    push   = 1'b0;
    logic    pop    = 1'b0;
    item_t   item   = '0;
    logic    full;
    logic    empty;
    result_t result;

    int mismatches;
    int outstanding;
    int beats_checked;

    int   items_sent  = 0;
    int   texts_ended = 0;
    int   burst_left  = 0;
    int   idle_cycles = 0;
    logic no_gaps     = 1'b0;
    logic hold_req    = 1'b0;
    logic held        = 1'b0;
    logic drained     = 1'b0;

    utf8_word_tokenizer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    utf8_word_tokenizer_checker u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        push <= 1'b1;
        item <= '{in_byte: b, end_of_text: e};
        do
            @(posedge clk);
        while (full);
        items_sent++;
        if (e)
            texts_ended++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // stop offering and wait until every predicted beat has been popped
    task automatic drain_pause();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_beat(8'h41, 1'b0);  // upper case folds to lower
        send_beat(8'h7A, 1'b0);
        send_beat(8'h30, 1'b0);
        send_beat(8'h27, 1'b0);
        send_beat(8'h2D, 1'b0);
        send_beat(8'h24, 1'b0);
        send_beat(8'h20, 1'b0);  // space closes the token
        send_beat(8'hC3, 1'b0);  // Latin-1 low and high ends
        send_beat(8'h80, 1'b0);
        send_beat(8'hC3, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'hD0, 1'b0);  // Cyrillic low and high ends
        send_beat(8'h80, 1'b0);
        send_beat(8'hD3, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'h80, 1'b0);  // stray continuation as lead
        send_beat(8'hC3, 1'b0);  // ASCII byte taken as continuation
        send_beat(8'h41, 1'b0);
        send_beat(8'hC1, 1'b0);  // overlong 'A'
        send_beat(8'h81, 1'b0);
        send_beat(8'hD0, 1'b1);  // text ends mid-sequence
        send_beat(8'hFF, 1'b0);  // bad lead, no open token
        send_beat(8'hF0, 1'b0);  // four-byte non-word char
        send_beat(8'h9F, 1'b0);
        send_beat(8'h98, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hD0, 1'b0);  // two-byte word char plus end of text
        send_beat(8'hB0, 1'b1);
    endtask

    task automatic emit_char();
        logic [7:0]  seq [4];
        logic [20:0] cp;
        int          len;
        int          roll;
        int          eot_at;
        int          i;
        roll = $urandom_range(0, 99);
        len  = 1;
        cp   = '0;
        if (roll < 30) begin
            seq[0] = (8'h41 + 8'($urandom_range(0, 25))) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        end else if (roll < 38) begin
            case ($urandom_range(0, 3))
                0:       seq[0] = 8'h30 + 8'($urandom_range(0, 9));
                1:       seq[0] = 8'h27;
                2:       seq[0] = 8'h2D;
                default: seq[0] = 8'h24;
            endcase
        end else if (roll < 50) begin
            seq[0] = 8'($urandom_range(0, 127));
        end else if (roll < 75) begin
            if (roll < 60)
                cp = 21'($urandom_range('hC0, 'hFF));
            else if (roll < 70)
                cp = 21'($urandom_range('h400, 'h4FF));
            else
                cp = 21'($urandom_range('h80, 'h7FF));
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            len = 2;
        end else if (roll < 80) begin
            cp = 21'($urandom_range(0, 'hFFFF));
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            len = 3;
        end else if (roll < 84) begin
            cp = 21'($urandom_range(0, 'h1FFFFF));
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            len = 4;
        end else if (roll < 88) begin
            seq[0] = $urandom_range(0, 1) ? 8'hC1 : 8'hC0;
            seq[1] = {2'b10, 6'($urandom_range(0, 63))};
            len = 2;
        end else if (roll < 92) begin
            seq[0] = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                          : 8'($urandom_range('hF8, 'hFF));
        end else if (roll < 96) begin
            // lead with junk or missing continuation bytes
            seq[0] = 8'($urandom_range('hC0, 'hF7));
            len = $urandom_range(1, 4);
            for (i = 1; i < len; i++)
                seq[i] = 8'($urandom);
        end else begin
            seq[0] = 8'($urandom);
        end

        eot_at = -1;
        if ($urandom_range(0, 19) == 0)
            eot_at = len - 1;
        else if ($urandom_range(0, 59) == 0)
            eot_at = $urandom_range(0, len - 1);
        for (i = 0; i < len; i++)
            send_beat(seq[i], i == eot_at);
    endtask

    // receiver stops popping while the sender streams word chars back to back
    task automatic hold_phase();
        int k;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (k = 0; k < 30; k++)
            send_beat(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rx_mode_e mode;
        int       seg_left;
        mode     = RX_STREAM;
        seg_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (seg_left == 0) begin
                mode     = rx_mode_e'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            case (mode)
                RX_STREAM: pop <= 1'b1;
                RX_COIN:   pop <= 1'($urandom_range(0, 1));
                RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:   pop <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no beat moved for %0d cycles, %0d beats still due",
                 WATCHDOG_LIMIT, outstanding);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        burst_left = $urandom_range(1, 40);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (items_sent < ITEM_TARGET) begin
            if (!held && items_sent >= 150) begin
                held = 1'b1;
                hold_phase();
            end
            if (!drained && items_sent >= 300) begin
                drained = 1'b1;
                drain_pause();
            end
            emit_char();
        end
        drain_pause();
        repeat (8) @(posedge clk);

        $display("covered %0d input bytes over %0d texts, %0d output beats checked",
                 items_sent, texts_ended, beats_checked);
        $display("included a %0d-cycle output hold under backpressure and a mid-run drain",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0 && empty)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/utf8tok_pkg.sv
hw/rtl/utf8tok_front.sv
hw/rtl/utf8tok_fifo.sv
hw/rtl/utf8tok_back.sv
hw/rtl/utf8_word_tokenizer_top.sv
hw/rtl/utf8tok_checker.sv
test/utf8_word_tokenizer_checker.sv
test/tb_utf8_word_tokenizer_top.sv
